/* design/vic_pkg.sv */
// shared constants and types for the vectored interrupt controller
package vic_pkg;

  localparam int unsigned REG_COUNT_DEF   = 128;
  localparam int unsigned NUM_SOURCES_DEF = 32;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned SRC_W  = 5;
  localparam int unsigned CMD_W  = 2;

  // item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_EVENT = 2'd2
  } cmd_t;

  // register word indexes
  localparam logic [IDX_W-1:0] IDX_SVR  = 7'd32;
  localparam logic [IDX_W-1:0] IDX_IVR  = 7'd64;
  localparam logic [IDX_W-1:0] IDX_FVR  = 7'd65;
  localparam logic [IDX_W-1:0] IDX_ISR  = 7'd66;
  localparam logic [IDX_W-1:0] IDX_IPR  = 7'd67;
  localparam logic [IDX_W-1:0] IDX_IMR  = 7'd68;
  localparam logic [IDX_W-1:0] IDX_CISR = 7'd69;
  localparam logic [IDX_W-1:0] IDX_IECR = 7'd72;
  localparam logic [IDX_W-1:0] IDX_IDCR = 7'd73;
  localparam logic [IDX_W-1:0] IDX_FFER = 7'd80;
  localparam logic [IDX_W-1:0] IDX_FFDR = 7'd81;
  localparam logic [IDX_W-1:0] IDX_FFSR = 7'd82;

  // result of a lowest-set-bit search
  typedef struct packed {
    logic             found;
    logic [SRC_W-1:0] idx;
  } prio_t;

  // lowest set bit of a source vector
  function automatic prio_t find_lowest(input logic [DATA_W-1:0] v);
    prio_t r;
    r = '0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = SRC_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* design/vic_ram.sv */
// generic single-write, single-read ram with registered read data
module vic_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/vectored_interrupt_controller_unit.sv */
// Vectored interrupt controller: register file, pending/mask logic and line priority.
// An accepted item passes through the input register, then the result register;
// throughput is one item per cycle while results are taken (out_ready), and a
// result that is not taken stalls the input register and so the input.
// Reset clears the status registers and the per-word valid bits of both rams; a
// ram word that was never written reads as zero, so no clearing pass is needed.
module vectored_interrupt_controller_unit #(
  parameter int unsigned REG_COUNT   = vic_pkg::REG_COUNT_DEF,
  parameter int unsigned NUM_SOURCES = vic_pkg::NUM_SOURCES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [vic_pkg::CMD_W-1:0]   cmd,
  input  logic [vic_pkg::IDX_W-1:0]   reg_index,
  input  logic [vic_pkg::DATA_W-1:0]  write_data,
  input  logic [vic_pkg::SRC_W-1:0]   source_id,
  input  logic                        source_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vic_pkg::DATA_W-1:0]  read_data,
  output logic                        irq_line,
  output logic                        fiq_line
);

  localparam int unsigned AW = $clog2(REG_COUNT);
  localparam int unsigned SW = $clog2(NUM_SOURCES);
  localparam int unsigned DW = vic_pkg::DATA_W;
  localparam logic [DW-1:0] SRC_MASK = DW'((64'd1 << NUM_SOURCES) - 64'd1);

  // input register
  logic                          s1_valid;
  vic_pkg::cmd_t                 s1_cmd;
  logic [vic_pkg::IDX_W-1:0]     s1_idx;
  logic [DW-1:0]                 s1_data;
  logic [vic_pkg::SRC_W-1:0]     s1_src;
  logic                          s1_level;

  // status registers held in flops
  logic [DW-1:0] ivr, fvr, isr, ipr, imr, ffsr, svr0;
  logic [1:0]    cisr;
  logic          ivr_pend;

  // ram side
  logic [REG_COUNT-1:0]   ram_vld;
  logic [NUM_SOURCES-1:0] svr_vld;
  logic [DW-1:0]          ram_rdata, svr_rdata;
  logic                   rd_hit, rd_vld;
  logic [DW-1:0]          rd_fwd;
  logic                   svr_hit, svr_rd_vld;
  logic [DW-1:0]          svr_fwd;

  logic          in_fire, s1_fire, in_range, s1_in_range;
  logic          s1_store, s1_svr, fwd_hit, svr_we, svr_fwd_hit;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [SW-1:0] svr_waddr, svr_raddr;
  logic [DW-1:0] ram_word, svr_val, ivr_eff, rd_val;
  logic [DW-1:0] ipr_next, imr_next, ffsr_next, isr_w, fvr_w, ivr_next, svr0_next;
  logic [DW-1:0] isr_next, fvr_next, src_pend, fiq_cand, irq_cand;
  vic_pkg::prio_t fiq_sel, irq_sel;

  // handshake
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // address decode
  assign rd_addr     = AW'(reg_index);
  assign wr_addr     = AW'(s1_idx);
  assign in_range    = 32'(reg_index) < REG_COUNT;
  assign s1_in_range = 32'(s1_idx) < REG_COUNT;

  // plain stores: every in-range write except the set/clear aliases and the IMR and FFSR words
  always_comb begin
    s1_store = 1'b0;
    if (s1_cmd == vic_pkg::CMD_WRITE && s1_in_range) begin
      unique case (s1_idx) inside
        vic_pkg::IDX_IECR, vic_pkg::IDX_IDCR, vic_pkg::IDX_FFER,
        vic_pkg::IDX_FFDR, vic_pkg::IDX_IMR, vic_pkg::IDX_FFSR: s1_store = 1'b0;
        default:                                                 s1_store = 1'b1;
      endcase
    end
  end

  assign s1_svr    = s1_store && (s1_idx >= vic_pkg::IDX_SVR)
                     && (32'(s1_idx) < 32'(vic_pkg::IDX_SVR) + NUM_SOURCES);
  assign svr_we    = s1_fire && s1_svr;
  assign svr_waddr = SW'(s1_idx - vic_pkg::IDX_SVR);
  assign fwd_hit   = s1_fire && s1_store && (s1_idx == reg_index);

  // main register file
  vic_ram #(.WIDTH(DW), .DEPTH(REG_COUNT)) u_file (
    .clk   (clk),
    .we    (s1_fire && s1_store),
    .waddr (wr_addr),
    .wdata (s1_data),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // copy of the source vector words, read at the winning normal source
  vic_ram #(.WIDTH(DW), .DEPTH(NUM_SOURCES)) u_svr (
    .clk   (clk),
    .we    (svr_we),
    .waddr (svr_waddr),
    .wdata (s1_data),
    .re    (s1_fire),
    .raddr (svr_raddr),
    .rdata (svr_rdata)
  );

  assign ram_word = rd_hit ? rd_fwd : (rd_vld ? ram_rdata : '0);
  assign svr_val  = svr_hit ? svr_fwd : (svr_rd_vld ? svr_rdata : '0);
  assign ivr_eff  = ivr_pend ? svr_val : ivr;

  // register write and line event effects
  always_comb begin
    ipr_next  = ipr;
    imr_next  = imr;
    ffsr_next = ffsr;
    isr_w     = isr;
    fvr_w     = fvr;
    ivr_next  = ivr_eff;
    svr0_next = svr0;
    if (s1_cmd == vic_pkg::CMD_WRITE && s1_in_range) begin
      unique case (s1_idx) inside
        vic_pkg::IDX_IECR: imr_next  = imr | s1_data;
        vic_pkg::IDX_IDCR: imr_next  = imr & ~s1_data;
        vic_pkg::IDX_FFER: ffsr_next = ffsr | s1_data;
        vic_pkg::IDX_FFDR: ffsr_next = ffsr & ~s1_data;
        vic_pkg::IDX_IPR:  ipr_next  = s1_data;
        vic_pkg::IDX_ISR:  isr_w     = s1_data;
        vic_pkg::IDX_FVR:  fvr_w     = s1_data;
        vic_pkg::IDX_IVR:  ivr_next  = s1_data;
        vic_pkg::IDX_SVR:  svr0_next = s1_data;
        default: ;
      endcase
    end else if (s1_cmd == vic_pkg::CMD_EVENT && 32'(s1_src) < NUM_SOURCES) begin
      ipr_next[s1_src] = s1_level;
    end
  end

  // fast and normal line priority
  assign src_pend = ipr_next & imr_next & SRC_MASK;
  assign fiq_cand = (ffsr_next & src_pend) | {{(DW-1){1'b0}}, src_pend[0]};
  assign irq_cand = ~ffsr_next & src_pend & ~DW'(1);
  assign fiq_sel  = vic_pkg::find_lowest(fiq_cand);
  assign irq_sel  = vic_pkg::find_lowest(irq_cand);

  assign isr_next = fiq_sel.found ? DW'(fiq_sel.idx)
                  : (irq_sel.found ? DW'(irq_sel.idx) : isr_w);
  assign fvr_next = fiq_sel.found ? svr0_next : fvr_w;
  assign svr_raddr   = SW'(irq_sel.idx);
  assign svr_fwd_hit = svr_we && (svr_waddr == svr_raddr);

  // register read, taken before the line update
  always_comb begin
    rd_val = '0;
    if (s1_cmd == vic_pkg::CMD_READ && s1_in_range) begin
      unique case (s1_idx) inside
        vic_pkg::IDX_IVR:  rd_val = ivr_eff;
        vic_pkg::IDX_FVR:  rd_val = fvr;
        vic_pkg::IDX_ISR:  rd_val = isr;
        vic_pkg::IDX_IPR:  rd_val = ipr;
        vic_pkg::IDX_IMR:  rd_val = imr;
        vic_pkg::IDX_CISR: rd_val = {{(DW-2){1'b0}}, cisr};
        vic_pkg::IDX_FFSR: rd_val = ffsr;
        default:           rd_val = ram_word;
      endcase
    end
  end

  // input register and ram read bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_fire) begin
      s1_cmd   <= vic_pkg::cmd_t'(cmd);
      s1_idx   <= reg_index;
      s1_data  <= write_data;
      s1_src   <= source_id;
      s1_level <= source_level;
      rd_hit   <= fwd_hit;
      rd_fwd   <= s1_data;
      rd_vld   <= in_range && ram_vld[rd_addr];
    end
    if (s1_fire) begin
      svr_hit    <= svr_fwd_hit;
      svr_fwd    <= s1_data;
      svr_rd_vld <= svr_vld[svr_raddr];
    end
  end

  // status registers and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ivr      <= '0;
      ivr_pend <= 1'b0;
      fvr      <= '0;
      isr      <= '0;
      ipr      <= '0;
      imr      <= '0;
      ffsr     <= '0;
      svr0     <= '0;
      cisr     <= '0;
      ram_vld  <= '0;
      svr_vld  <= '0;
    end else if (s1_fire) begin
      ivr      <= ivr_next;
      ivr_pend <= irq_sel.found;
      fvr      <= fvr_next;
      isr      <= isr_next;
      ipr      <= ipr_next;
      imr      <= imr_next;
      ffsr     <= ffsr_next;
      svr0     <= svr0_next;
      cisr     <= {irq_sel.found, fiq_sel.found};
      if (s1_store) begin
        ram_vld[wr_addr] <= 1'b1;
      end
      if (s1_svr) begin
        svr_vld[svr_waddr] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire) begin
      read_data <= rd_val;
      irq_line  <= irq_sel.found;
      fiq_line  <= fiq_sel.found;
    end
  end

endmodule
